// ===== hw/rtl/mck_pkg.sv =====
// mck_pkg: shared types, constants and the character-to-pattern table
// of the morse character keyer; depends on nothing
`timescale 1ns / 1ps

package mck_pkg;

  localparam int unsigned CharWidth     = 8;
  localparam int unsigned UnitWidth     = 10;
  localparam int unsigned OnWidth       = 12;
  localparam int unsigned OffWidth      = 13;
  localparam int unsigned MaxElems      = 5;
  localparam int unsigned LenWidth      = $clog2(MaxElems + 1);

  localparam logic [UnitWidth-1:0] TimeUnitReset = 10'd60;

  // element lengths in time units
  localparam logic [1:0] DotOnUnits    = 2'd1;
  localparam logic [1:0] DashOnUnits   = 2'd3;
  localparam logic [2:0] DotOffUnits   = 3'd2;
  localparam logic [2:0] DashOffUnits  = 3'd4;
  localparam logic [2:0] CharGapUnits  = 3'd3;
  localparam logic [2:0] WordGapUnits  = 3'd7;

  // case folding: lower-case letters sit this far above upper-case ones
  localparam logic [CharWidth-1:0] CaseOffset = 8'd32;

  // keying pattern of one character, first element in the msb, 1 = dash
  typedef struct packed {
    logic                space;
    logic [LenWidth-1:0] len;
    logic [MaxElems-1:0] dash;
  } pat_t;

  // one element handed from the pattern stage to the output stage
  typedef struct packed {
    logic space;
    logic dash;
    logic last;
  } elem_t;

  function automatic pat_t char_to_pat(input logic [CharWidth-1:0] code);
    logic [CharWidth-1:0] up;
    pat_t                 p;
    up = code;
    if (code >= "a" && code <= "z") begin
      up = code - CaseOffset;
    end
    p = '{space: 1'b0, len: '0, dash: '0};
    unique case (up)
      " ": p = '{space: 1'b1, len: 3'd1, dash: 5'b00000};
      "A": p = '{space: 1'b0, len: 3'd2, dash: 5'b01000};
      "B": p = '{space: 1'b0, len: 3'd4, dash: 5'b10000};
      "C": p = '{space: 1'b0, len: 3'd4, dash: 5'b10100};
      "D": p = '{space: 1'b0, len: 3'd3, dash: 5'b10000};
      "E": p = '{space: 1'b0, len: 3'd1, dash: 5'b00000};
      "F": p = '{space: 1'b0, len: 3'd4, dash: 5'b00100};
      "G": p = '{space: 1'b0, len: 3'd3, dash: 5'b11000};
      "H": p = '{space: 1'b0, len: 3'd4, dash: 5'b00000};
      "I": p = '{space: 1'b0, len: 3'd2, dash: 5'b00000};
      "J": p = '{space: 1'b0, len: 3'd4, dash: 5'b01110};
      "K": p = '{space: 1'b0, len: 3'd3, dash: 5'b10100};
      "L": p = '{space: 1'b0, len: 3'd4, dash: 5'b01000};
      "M": p = '{space: 1'b0, len: 3'd2, dash: 5'b11000};
      "N": p = '{space: 1'b0, len: 3'd2, dash: 5'b10000};
      "O": p = '{space: 1'b0, len: 3'd3, dash: 5'b11100};
      "P": p = '{space: 1'b0, len: 3'd4, dash: 5'b01100};
      "Q": p = '{space: 1'b0, len: 3'd4, dash: 5'b11010};
      "R": p = '{space: 1'b0, len: 3'd3, dash: 5'b01000};
      "S": p = '{space: 1'b0, len: 3'd3, dash: 5'b00000};
      "T": p = '{space: 1'b0, len: 3'd1, dash: 5'b10000};
      "U": p = '{space: 1'b0, len: 3'd3, dash: 5'b00100};
      "V": p = '{space: 1'b0, len: 3'd4, dash: 5'b00010};
      "W": p = '{space: 1'b0, len: 3'd3, dash: 5'b01100};
      "X": p = '{space: 1'b0, len: 3'd4, dash: 5'b10010};
      "Y": p = '{space: 1'b0, len: 3'd4, dash: 5'b10110};
      "Z": p = '{space: 1'b0, len: 3'd4, dash: 5'b11000};
      "0": p = '{space: 1'b0, len: 3'd5, dash: 5'b11111};
      "1": p = '{space: 1'b0, len: 3'd5, dash: 5'b01111};
      "2": p = '{space: 1'b0, len: 3'd5, dash: 5'b00111};
      "3": p = '{space: 1'b0, len: 3'd5, dash: 5'b00011};
      "4": p = '{space: 1'b0, len: 3'd5, dash: 5'b00001};
      "5": p = '{space: 1'b0, len: 3'd5, dash: 5'b00000};
      "6": p = '{space: 1'b0, len: 3'd5, dash: 5'b10000};
      "7": p = '{space: 1'b0, len: 3'd5, dash: 5'b11000};
      "8": p = '{space: 1'b0, len: 3'd5, dash: 5'b11100};
      "9": p = '{space: 1'b0, len: 3'd5, dash: 5'b11110};
      default: p = '{space: 1'b0, len: '0, dash: '0};
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/mck_char_stage.sv =====
// mck_char_stage: input register holding the keying pattern of the current
// character and stepping through its elements; depends on mck_pkg
`timescale 1ns / 1ps

module mck_char_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          char_valid_i,
  output logic                          char_ready_o,
  input  logic [mck_pkg::CharWidth-1:0] char_code_i,
  input  logic                          advance_i,
  output logic                          elem_valid_o,
  output mck_pkg::elem_t                elem_o
);

  mck_pkg::pat_t                       pat;
  logic                                accept;
  logic                                on_last;
  logic                                pat_valid_q, pat_valid_d;
  logic [mck_pkg::LenWidth-1:0]        left_q, left_d;
  logic [mck_pkg::MaxElems-1:0]        dash_q, dash_d;
  logic                                space_q, space_d;

  assign pat     = mck_pkg::char_to_pat(char_code_i);
  assign on_last = (left_q == mck_pkg::LenWidth'(1));

  // free when empty or when the final element leaves this cycle
  assign char_ready_o = !pat_valid_q || (advance_i && on_last);
  assign accept       = char_valid_i && char_ready_o;

  always_comb begin
    pat_valid_d = pat_valid_q;
    left_d      = left_q;
    dash_d      = dash_q;
    space_d     = space_q;
    if (accept) begin
      // unknown characters have no elements and leave the stage empty
      pat_valid_d = (pat.len != '0);
      left_d      = pat.len;
      dash_d      = pat.dash;
      space_d     = pat.space;
    end else if (advance_i) begin
      pat_valid_d = !on_last;
      left_d      = left_q - mck_pkg::LenWidth'(1);
      dash_d      = {dash_q[mck_pkg::MaxElems-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_valid_q <= 1'b0;
    end else begin
      pat_valid_q <= pat_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    dash_q  <= dash_d;
    space_q <= space_d;
  end

  assign elem_valid_o = pat_valid_q;
  assign elem_o       = '{space: space_q, dash: dash_q[mck_pkg::MaxElems-1], last: on_last};

endmodule

// ===== hw/rtl/mck_elem_stage.sv =====
// mck_elem_stage: scales one element by the time unit into the result
// register; depends on mck_pkg
`timescale 1ns / 1ps

module mck_elem_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          elem_valid_i,
  input  mck_pkg::elem_t                elem_i,
  output logic                          advance_o,
  input  logic [mck_pkg::UnitWidth-1:0] time_unit_i,
  output logic                          elem_valid_o,
  input  logic                          elem_ready_i,
  output logic [mck_pkg::OnWidth-1:0]   on_time_o,
  output logic [mck_pkg::OffWidth-1:0]  off_time_o,
  output logic                          last_element_o
);

  logic [1:0]                    on_units;
  logic [2:0]                    off_units;
  logic                          out_valid_q, out_valid_d;
  logic [mck_pkg::OnWidth-1:0]   on_time_q, on_time_d;
  logic [mck_pkg::OffWidth-1:0]  off_time_q, off_time_d;
  logic                          last_q, last_d;

  assign advance_o = elem_valid_i && (!out_valid_q || elem_ready_i);

  always_comb begin
    if (elem_i.space) begin
      on_units  = 2'd0;
      off_units = mck_pkg::WordGapUnits;
    end else begin
      on_units  = elem_i.dash ? mck_pkg::DashOnUnits : mck_pkg::DotOnUnits;
      off_units = (elem_i.dash ? mck_pkg::DashOffUnits : mck_pkg::DotOffUnits)
                + (elem_i.last ? mck_pkg::CharGapUnits : 3'd0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    on_time_d   = on_time_q;
    off_time_d  = off_time_q;
    last_d      = last_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
      on_time_d   = mck_pkg::OnWidth'(on_units) * mck_pkg::OnWidth'(time_unit_i);
      off_time_d  = mck_pkg::OffWidth'(off_units) * mck_pkg::OffWidth'(time_unit_i);
      last_d      = elem_i.last;
    end else if (elem_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    on_time_q  <= on_time_d;
    off_time_q <= off_time_d;
    last_q     <= last_d;
  end

  assign elem_valid_o   = out_valid_q;
  assign on_time_o      = on_time_q;
  assign off_time_o     = off_time_q;
  assign last_element_o = last_q;

endmodule

// ===== hw/rtl/morse_character_keyer_core.sv =====
// morse_character_keyer_core: top level of the morse character keyer
// depends on mck_pkg, mck_char_stage and mck_elem_stage
`timescale 1ns / 1ps

// usage
// - char channel (char_valid_i / char_ready_o / char_code_i) takes one ascii
//   character per transaction; letters in either case, digits and space
// - elem channel (elem_valid_o / elem_ready_i) gives one keying element per
//   transaction: on_time_o, off_time_o in timer ticks, last_element_o on the
//   final element of the character
// - time_unit_we_i writes time_unit_wdata_i into the unit length register;
//   write only while no character is in flight
// - the first element passes the pattern register, which loads at the
//   accepting edge, and then the result register, which loads from it once
//   the result register is free or its element is taken
// - throughput: one element per cycle while elem_ready_i stays high; a
//   character holds the pattern register until its final element leaves,
//   and a new char can be taken as it leaves; a space gives one element, an
//   unknown character gives no element
// - a stalled receiver holds the result register, and the pattern register
//   waits behind it; char_ready_o drops once the pattern register is busy
// - reset empties both registers and sets the unit length to 60 ticks
module morse_character_keyer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          char_valid_i,
  output logic                          char_ready_o,
  input  logic [mck_pkg::CharWidth-1:0] char_code_i,
  input  logic                          time_unit_we_i,
  input  logic [mck_pkg::UnitWidth-1:0] time_unit_wdata_i,
  output logic                          elem_valid_o,
  input  logic                          elem_ready_i,
  output logic [mck_pkg::OnWidth-1:0]   on_time_o,
  output logic [mck_pkg::OffWidth-1:0]  off_time_o,
  output logic                          last_element_o
);

  // unit length register
  logic [mck_pkg::UnitWidth-1:0] time_unit_q;

  // hand-off between the pattern stage and the result stage
  logic           elem_valid;
  mck_pkg::elem_t elem;
  logic           advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_unit_q <= mck_pkg::TimeUnitReset;
    end else if (time_unit_we_i) begin
      time_unit_q <= time_unit_wdata_i;
    end
  end

  // pattern lookup and element stepping
  mck_char_stage u_char_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid_i),
    .char_ready_o (char_ready_o),
    .char_code_i  (char_code_i),
    .advance_i    (advance),
    .elem_valid_o (elem_valid),
    .elem_o       (elem)
  );

  // scaling by the time unit into the result register
  mck_elem_stage u_elem_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .elem_valid_i   (elem_valid),
    .elem_i         (elem),
    .advance_o      (advance),
    .time_unit_i    (time_unit_q),
    .elem_valid_o   (elem_valid_o),
    .elem_ready_i   (elem_ready_i),
    .on_time_o      (on_time_o),
    .off_time_o     (off_time_o),
    .last_element_o (last_element_o)
  );

endmodule

// ===== hw/rtl/mck_checker.sv =====
// mck_checker: port-level assertions for the morse character keyer and the
// bind that attaches them; depends on morse_character_keyer_core
`timescale 1ns / 1ps

module mck_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          char_valid_i,
  input logic                          char_ready_o,
  input logic                          elem_valid_o,
  input logic                          elem_ready_i,
  input logic [mck_pkg::OnWidth-1:0]   on_time_o,
  input logic [mck_pkg::OffWidth-1:0]  off_time_o,
  input logic                          last_element_o
);

  // a stalled element stays offered
  a_elem_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_o && !elem_ready_i |=> elem_valid_o)
    else $error("element dropped while stalled");

  // every element keys off at least as long as it keys on
  a_off_ge_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_o |-> off_time_o >= on_time_o)
    else $error("off time shorter than on time");

  // the rest of a character follows without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_o && elem_ready_i && !last_element_o |=> elem_valid_o)
    else $error("gap inside a character");

  // no new character while the current one is stalled mid-way
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_o && !elem_ready_i && !last_element_o |-> !char_ready_o)
    else $error("char taken while the current one is stalled");

endmodule

bind morse_character_keyer_core mck_checker u_mck_checker (.*);
